>>> hdl/pfww_pkg.sv
`default_nettype none

package pfww_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OUTPUT_LENGTH = 2'd1;

    localparam logic [15:0] MAX_LINE_WIDTH_RESET    = 16'hFFFF;
    localparam logic [15:0] MAX_OUTPUT_LENGTH_RESET = 16'hFFFF;
    localparam logic [15:0] LINE_COUNT_MAX          = 16'hFFFF;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_NONE  = 8'd0;

    localparam logic [8:0] SPACE_PIXELS   = 9'd4;
    localparam logic [8:0] WORD_WIDTH_MAX = 9'd511;

    localparam logic [3:0] FONT_PX [128] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd4, 4'd2, 4'd4, 4'd7, 4'd6, 4'd9, 4'd7, 4'd2,
        4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd7,
        4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7,
        4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd8, 4'd8, 4'd6,
        4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd10,
        4'd8, 4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6,
        4'd4, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6,
        4'd6, 4'd2, 4'd5, 4'd5, 4'd2, 4'd9, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd4, 4'd2, 4'd5, 4'd7, 4'd0
    };

    typedef struct packed {
        logic accept;
        logic plan;
        logic fetch;
        logic push;
    } pfww_cmd_t;

    typedef struct packed {
        logic out_free;
        logic at_last;
    } pfww_stat_t;

    // codes 128..255 are one pixel wide
    function automatic logic [3:0] glyph_px(input logic [7:0] c);
        logic [3:0] px;
        if (c[7])
        begin
            px = 4'd1;
        end
        else
        begin
            px = FONT_PX[c[6:0]];
        end
        return px;
    endfunction

endpackage

`default_nettype wire

>>> hdl/proportional_font_word_wrap_top.sv
`default_nettype none

// Greedy word wrap to a pixel width for a proportional font. Bytes are taken one
// at a time; a word is held in a MAX_WORD-entry buffer until a space, CR/LF or
// end of text, then re-emitted after a space or newline separator, and a newline
// closes every source line that held text. Each accepted byte returns one or more
// output words, the final one marked by last; a byte that emits nothing returns a
// single word with char_valid low. One byte is in flight at a time: once it is
// accepted it is planned, then each output word takes a fetch step and a push
// step, and the next byte is taken only after the last word has been loaded; an
// output stall holds the push. The fetch step reads the word buffer and the push
// step loads the output register. Configuration writes are always taken
// (cfg_ready is tied high) and belong between texts or while the block is idle.
// No clearing pass follows reset.

module proportional_font_word_wrap_top #(
    parameter int MAX_WORD = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       char_code,
    input  wire logic                             end_of_text,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            out_char,
    output logic                                  char_valid,
    output logic                                  last,
    output logic [15:0]                           line_count,
    output logic                                  word_truncated,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pfww_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                      cfg_data
);
    import pfww_pkg::*;

    pfww_cmd_t  cmd;
    pfww_stat_t stat;

    assign cfg_ready = 1'b1;

    pfww_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfww_datapath #(
        .MAX_WORD (MAX_WORD)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .char_code      (char_code),
        .end_of_text    (end_of_text),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .char_valid     (char_valid),
        .last           (last),
        .line_count     (line_count),
        .word_truncated (word_truncated)
    );

    // an accepted byte blocks the input until its last word is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a byte");

    // a waiting output word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !cmd.push)
        else $error("output word overwritten while stalled");

    // the empty result is always the only word of its byte
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> last)
        else $error("empty result not marked last");

    // the input reopens only after a final word has been loaded
    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid && last)
        else $error("input reopened before the last word");

endmodule

`default_nettype wire

>>> hdl/pfww_ctrl.sv
`default_nettype none

module pfww_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire pfww_pkg::pfww_stat_t  stat,
    output pfww_pkg::pfww_cmd_t        cmd
);
    import pfww_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAN,
        S_FETCH,
        S_PUSH
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_PLAN;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_PLAN:
                begin
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (stat.out_free)
                    begin
                        if (stat.at_last)
                        begin
                            state_reg    <= S_IDLE;
                            in_stall_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_FETCH;
                        end
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_stall = in_stall_reg;

    always_comb
    begin
        cmd.accept = (state_reg == S_IDLE) && in_valid;
        cmd.plan   = (state_reg == S_PLAN);
        cmd.fetch  = (state_reg == S_FETCH);
        cmd.push   = (state_reg == S_PUSH) && stat.out_free;
    end

endmodule

`default_nettype wire

>>> hdl/pfww_datapath.sv
`default_nettype none

module pfww_datapath #(
    parameter int MAX_WORD = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pfww_pkg::pfww_cmd_t              cmd,
    output pfww_pkg::pfww_stat_t                  stat,
    input  wire logic [7:0]                       char_code,
    input  wire logic                             end_of_text,
    input  wire logic                             cfg_we,
    input  wire logic [pfww_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                      cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            out_char,
    output logic                                  char_valid,
    output logic                                  last,
    output logic [15:0]                           line_count,
    output logic                                  word_truncated
);
    import pfww_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int CW = $clog2(MAX_WORD + 3);

    logic [15:0]   mlw_reg;
    logic [15:0]   mol_reg;
    logic [7:0]    item_char_reg;
    logic          item_eot_reg;
    logic [7:0]    word_mem [MAX_WORD];
    logic [LW-1:0] wlen_reg;
    logic [8:0]    wwid_reg;
    logic [17:0]   lpix_reg;
    logic          lopen_reg;
    logic [15:0]   emit_cnt_reg;
    logic [15:0]   lines_reg;
    logic          trunc_reg;

    logic          plan_sep_reg;
    logic          plan_nl_reg;
    logic [LW-1:0] plan_len_reg;
    logic [CW-1:0] plan_cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [15:0]   res_lc_reg;
    logic          res_tr_reg;
    logic [7:0]    rd_data_reg;
    logic          src_word_reg;
    logic [7:0]    fix_char_reg;

    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          char_valid_reg;
    logic          last_reg;
    logic [15:0]   line_count_reg;
    logic          trunc_out_reg;

    // item classification
    logic          is_space;
    logic          is_eol;
    logic          is_brk;
    logic          closes;
    logic          flush;
    logic          has_sep;
    logic [17:0]   line_sum;
    logic          sep_nl;
    logic          close_nl;
    logic [15:0]   lines_mid;
    logic [15:0]   lines_next;
    logic [CW-1:0] n_plan;
    logic [15:0]   cap;
    logic [16:0]   room_diff;
    logic [15:0]   room;
    logic [CW-1:0] n_act;
    logic [17:0]   lpix_next;
    logic [9:0]    wsum;
    logic [8:0]    wwid_next;
    logic          word_full;
    logic          mem_we;
    logic [CW-1:0] j_idx;
    logic          in_word;
    logic          mem_re;
    logic [CW-1:0] idx_inc;

    always_comb
    begin
        is_space  = (item_char_reg == CHAR_SPACE);
        is_eol    = (item_char_reg == CHAR_LF) || (item_char_reg == CHAR_CR);
        is_brk    = item_eot_reg || is_space || is_eol;
        closes    = item_eot_reg || is_eol;
        flush     = (wlen_reg != '0);
        has_sep   = flush && (lpix_reg != '0);
        line_sum  = lpix_reg + {9'b0, wwid_reg};
        sep_nl    = has_sep && (line_sum > {2'b0, mlw_reg});
        close_nl  = closes && lopen_reg;

        lines_mid  = (sep_nl && (lines_reg != LINE_COUNT_MAX)) ? lines_reg + 16'd1 : lines_reg;
        lines_next = (close_nl && (lines_mid != LINE_COUNT_MAX)) ? lines_mid + 16'd1 : lines_mid;

        n_plan = CW'(has_sep) + CW'(wlen_reg) + CW'(close_nl);

        // room left in the output: cap - 1 - emitted, floored at zero
        cap       = (mol_reg == '0) ? 16'd1 : mol_reg;
        room_diff = {1'b0, cap} - 17'd1 - {1'b0, emit_cnt_reg};
        room      = room_diff[16] ? 16'd0 : room_diff[15:0];
        n_act     = ({{(16-CW){1'b0}}, n_plan} > room) ? CW'(room) : n_plan;

        if (flush)
        begin
            lpix_next = (sep_nl ? 18'd0 : lpix_reg) + {9'b0, wwid_reg} + 18'(SPACE_PIXELS);
        end
        else
        begin
            lpix_next = lpix_reg;
        end

        wsum      = {1'b0, wwid_reg} + {6'b0, glyph_px(item_char_reg)};
        wwid_next = wsum[9] ? WORD_WIDTH_MAX : wsum[8:0];
        word_full = (wlen_reg >= LW'(MAX_WORD));
        mem_we    = cmd.plan && !is_brk && !word_full;

        j_idx   = idx_reg - CW'(plan_sep_reg);
        in_word = !(plan_sep_reg && (idx_reg == '0)) && (j_idx < CW'(plan_len_reg));
        mem_re  = cmd.fetch && in_word;
        idx_inc = idx_reg + CW'(1);

        stat.out_free = !out_valid_reg || !out_stall;
        stat.at_last  = (plan_cnt_reg == '0) || (idx_inc == plan_cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            word_mem[wlen_reg[AW-1:0]] <= item_char_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= word_mem[j_idx[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mlw_reg       <= MAX_LINE_WIDTH_RESET;
            mol_reg       <= MAX_OUTPUT_LENGTH_RESET;
            wlen_reg      <= '0;
            wwid_reg      <= '0;
            lpix_reg      <= '0;
            lopen_reg     <= 1'b0;
            emit_cnt_reg  <= '0;
            lines_reg     <= '0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_LINE_WIDTH:    mlw_reg <= cfg_data;
                    CFG_MAX_OUTPUT_LENGTH: mol_reg <= cfg_data;
                    default:               ;
                endcase
            end

            if (cmd.plan)
            begin
                if (is_brk)
                begin
                    wlen_reg     <= '0;
                    wwid_reg     <= '0;
                    lpix_reg     <= closes ? 18'd0 : lpix_next;
                    // end of text closes the line whatever its byte holds
                    lopen_reg    <= is_space && !item_eot_reg;
                    lines_reg    <= item_eot_reg ? 16'd0 : lines_next;
                    emit_cnt_reg <= item_eot_reg ? 16'd0
                                                 : emit_cnt_reg + {{(16-CW){1'b0}}, n_act};
                    if (item_eot_reg)
                    begin
                        trunc_reg <= 1'b0;
                    end
                end
                else
                begin
                    lopen_reg <= 1'b1;
                    if (word_full)
                    begin
                        trunc_reg <= 1'b1;
                    end
                    else
                    begin
                        wlen_reg <= wlen_reg + LW'(1);
                        wwid_reg <= wwid_next;
                    end
                end
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_char_reg <= char_code;
            item_eot_reg  <= end_of_text;
        end

        if (cmd.plan)
        begin
            idx_reg      <= '0;
            plan_sep_reg <= is_brk && has_sep;
            plan_nl_reg  <= sep_nl;
            plan_len_reg <= wlen_reg;
            if (is_brk)
            begin
                plan_cnt_reg <= n_act;
                res_lc_reg   <= lines_next;
                res_tr_reg   <= trunc_reg;
            end
            else
            begin
                plan_cnt_reg <= '0;
                res_lc_reg   <= lines_reg;
                res_tr_reg   <= trunc_reg || word_full;
            end
        end

        if (cmd.fetch)
        begin
            src_word_reg <= in_word;
            if (plan_sep_reg && (idx_reg == '0))
            begin
                fix_char_reg <= plan_nl_reg ? CHAR_LF : CHAR_SPACE;
            end
            else
            begin
                fix_char_reg <= CHAR_LF;
            end
        end

        if (cmd.push)
        begin
            idx_reg        <= idx_inc;
            char_valid_reg <= (plan_cnt_reg != '0);
            last_reg       <= stat.at_last;
            line_count_reg <= res_lc_reg;
            trunc_out_reg  <= res_tr_reg;
            if (plan_cnt_reg == '0)
            begin
                out_char_reg <= CHAR_NONE;
            end
            else
            begin
                out_char_reg <= src_word_reg ? rd_data_reg : fix_char_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign char_valid     = char_valid_reg;
    assign last           = last_reg;
    assign line_count     = line_count_reg;
    assign word_truncated = trunc_out_reg;

endmodule

`default_nettype wire

>>> bench/wrap_checker.sv
`timescale 1ns / 100ps

module wrap_checker #(
    parameter int MAX_WORD = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [7:0]                       char_code,
    input  wire logic                             end_of_text,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [7:0]                       out_char,
    input  wire logic                             char_valid,
    input  wire logic                             last,
    input  wire logic [15:0]                      line_count,
    input  wire logic                             word_truncated,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [pfww_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                      cfg_data,
    output int                                    mismatches,
    output int                                    words_owed
);

    import pfww_pkg::*;

    typedef struct packed {
        logic [7:0]  ch;
        logic        ch_valid;
        logic        fin;
        logic [15:0] lines;
        logic        trunc;
    } wrap_word_t;

    wrap_word_t owed_q[$];

    logic [15:0] width_limit;
    logic [15:0] length_limit;
    logic [7:0]  held_word[$];
    logic [7:0]  step_chars[$];
    int          held_px;
    int          line_px;
    bit          line_busy;
    int          sent_chars;
    int          lines_seen;
    bit          cut_flag;

    task automatic put_char(input logic [7:0] c);
        int cap;
        cap = (length_limit == 16'd0) ? 1 : int'(length_limit);
        if (sent_chars + 1 < cap && step_chars.size() < MAX_WORD + 3)
        begin
            step_chars.push_back(c);
            sent_chars++;
        end
    endtask

    task automatic bump_lines();
        if (lines_seen < int'(LINE_COUNT_MAX))
        begin
            lines_seen++;
        end
    endtask

    task automatic flush_held();
        if (held_word.size() == 0)
        begin
            return;
        end
        if (line_px != 0)
        begin
            if (line_px + held_px > int'(width_limit))
            begin
                put_char(CHAR_LF);
                line_px = 0;
                bump_lines();
            end
            else
            begin
                put_char(CHAR_SPACE);
            end
        end
        foreach (held_word[i])
        begin
            put_char(held_word[i]);
        end
        line_px += held_px + int'(SPACE_PIXELS);
        held_word.delete();
        held_px = 0;
    endtask

    task automatic end_line();
        if (line_busy)
        begin
            bump_lines();
            put_char(CHAR_LF);
        end
        line_busy = 1'b0;
        line_px = 0;
    endtask

    task automatic clear_text();
        held_word.delete();
        held_px = 0;
        line_px = 0;
        line_busy = 1'b0;
        sent_chars = 0;
        lines_seen = 0;
        cut_flag = 1'b0;
    endtask

    // wrap one accepted byte and queue the output words it causes
    task automatic wrap_byte(input logic [7:0] c, input logic eot);
        wrap_word_t w;
        step_chars.delete();
        if (eot)
        begin
            flush_held();
            end_line();
        end
        else if (c == CHAR_SPACE)
        begin
            flush_held();
            line_busy = 1'b1;
        end
        else if (c == CHAR_LF || c == CHAR_CR)
        begin
            flush_held();
            end_line();
        end
        else
        begin
            line_busy = 1'b1;
            if (held_word.size() < MAX_WORD)
            begin
                held_word.push_back(c);
                held_px += c[7] ? 1 : int'(FONT_PX[c[6:0]]);
                if (held_px > int'(WORD_WIDTH_MAX))
                begin
                    held_px = int'(WORD_WIDTH_MAX);
                end
            end
            else
            begin
                cut_flag = 1'b1;
            end
        end

        w.lines = 16'(lines_seen);
        w.trunc = cut_flag;
        if (step_chars.size() == 0)
        begin
            w.ch = CHAR_NONE;
            w.ch_valid = 1'b0;
            w.fin = 1'b1;
            owed_q.push_back(w);
        end
        else
        begin
            foreach (step_chars[k])
            begin
                w.ch = step_chars[k];
                w.ch_valid = 1'b1;
                w.fin = (k == step_chars.size() - 1);
                owed_q.push_back(w);
            end
        end

        if (eot)
        begin
            clear_text();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_limit = MAX_LINE_WIDTH_RESET;
            length_limit = MAX_OUTPUT_LENGTH_RESET;
            owed_q.delete();
            clear_text();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("output word with none expected: out_char %0d", out_char);
                    mismatches++;
                end
                else
                begin
                    wrap_word_t w;
                    w = owed_q.pop_front();
                    check_field("out_char", 16'(w.ch), 16'(out_char));
                    check_field("char_valid", 16'(w.ch_valid), 16'(char_valid));
                    check_field("last", 16'(w.fin), 16'(last));
                    check_field("line_count", w.lines, line_count);
                    check_field("word_truncated", 16'(w.trunc), 16'(word_truncated));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAX_LINE_WIDTH)
                begin
                    width_limit = cfg_data;
                end
                else if (cfg_index == CFG_MAX_OUTPUT_LENGTH)
                begin
                    length_limit = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                wrap_byte(char_code, end_of_text);
            end
        end
        words_owed = owed_q.size();
    end

endmodule

>>> bench/proportional_font_word_wrap_top_test.sv
`timescale 1ns / 100ps

module proportional_font_word_wrap_top_test;

    import pfww_pkg::*;

    localparam int RANDOM_ITEMS = 140;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             char_code;
    logic                   end_of_text;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             out_char;
    logic                   char_valid;
    logic                   last;
    logic [15:0]            line_count;
    logic                   word_truncated;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;

    int mismatches;
    int words_owed;
    int items_sent;
    bit idle_on;
    bit hold_req;

    proportional_font_word_wrap_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .char_valid     (char_valid),
        .last           (last),
        .line_count     (line_count),
        .word_truncated (word_truncated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    wrap_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .char_valid     (char_valid),
        .last           (last),
        .line_count     (line_count),
        .word_truncated (word_truncated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .words_owed     (words_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // output side: short random stalls, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (120) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // called at a rising edge; returns at the accepting edge or after a gap
    task automatic send_byte(input logic [7:0] c, input logic eot);
        in_valid <= 1'b1;
        char_code <= c;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_string(input string s);
        foreach (s[i])
        begin
            send_byte(8'(s[i]), 1'b0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (words_owed != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 9) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic send_text();
        int n_words;
        int len;
        int sep;
        n_words = $urandom_range(1, 8);
        for (int w = 0; w < n_words; w++)
        begin
            len = ($urandom_range(0, 12) == 0) ? $urandom_range(33, 36)
                                               : $urandom_range(1, 7);
            repeat (len) send_byte(text_char(), 1'b0);
            sep = $urandom_range(0, 9);
            if (sep <= 5)
            begin
                send_byte(CHAR_SPACE, 1'b0);
            end
            else if (sep == 6)
            begin
                send_string("  ");
            end
            else if (sep == 7)
            begin
                send_byte(CHAR_LF, 1'b0);
            end
            else if (sep == 8)
            begin
                send_byte(CHAR_CR, 1'b0);
                send_byte(CHAR_LF, 1'b0);
            end
            else
            begin
                send_byte(CHAR_LF, 1'b0);
                send_byte(CHAR_LF, 1'b0);
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        int sel;
        int first_random;
        int text_no;
        logic [15:0] line_w;
        logic [15:0] out_len;

        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = 8'd0;
        end_of_text = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_LINE_WIDTH;
        cfg_data = 16'd0;
        items_sent = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: null byte, high codes, doubled space, CR, empty lines
        send_byte("H", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_string("  w");
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        // zero width and zero capacity: nothing emitted, lines still counted
        write_reg(CFG_MAX_LINE_WIDTH, 16'd0);
        write_reg(CFG_MAX_OUTPUT_LENGTH, 16'd0);
        send_string("a b");
        send_byte(8'h7F, 1'b1);
        wait_drained();

        // narrow line with the output filling up
        write_reg(CFG_MAX_LINE_WIDTH, 16'd10);
        write_reg(CFG_MAX_OUTPUT_LENGTH, 16'd5);
        send_string("ab cd ef");
        send_byte(8'h00, 1'b1);
        wait_drained();

        first_random = items_sent;
        text_no = 0;
        while (items_sent < first_random + RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 3);
            line_w = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF
                                                     : 16'($urandom_range(5, 80));
            sel = $urandom_range(0, 3);
            out_len = (sel == 0) ? 16'd1 : (sel == 1) ? 16'hFFFF
                                                      : 16'($urandom_range(2, 60));
            write_reg(CFG_MAX_LINE_WIDTH, line_w);
            write_reg(CFG_MAX_OUTPUT_LENGTH, out_len);

            if (items_sent > first_random + RANDOM_ITEMS - 30)
            begin
                idle_on = 1'b0;
            end
            else
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (text_no == 1)
            begin
                hold_req = 1'b1;
            end

            send_text();
            wait_drained();
            text_no++;
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && words_owed == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
